FILE: src/next_fit_id_table_defines.svh
// Assertion macros shared by the next-fit ID table RTL.
// Used by nft_dp; expects clk and rst_n in the calling scope.
`ifndef NEXT_FIT_ID_TABLE_DEFINES_SVH
`define NEXT_FIT_ID_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked outside reset
`define NFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("next_fit_id_table: assertion failed");
// Property checked also while reset is held
`define NFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("next_fit_id_table: assertion failed");
`else
`define NFT_ASSERT(lbl, prop)
`define NFT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: src/nft_pkg.sv
// Package for the next-fit ID table: field types, codes, command/status structs.
// No dependencies; imported by every other file of the block except the defines header.
package nft_pkg;

  localparam int SLOT_COUNT_DEF   = 1024;
  localparam int HANDLE_BITS_DEF  = 32;

  localparam int OPCODE_BITS      = 2;
  localparam int STATUS_BITS      = 2;
  localparam int ID_BITS          = 10;
  localparam int PORT_HANDLE_BITS = 32;

  typedef logic [OPCODE_BITS-1:0]      opcode_t;
  typedef logic [STATUS_BITS-1:0]      status_t;
  typedef logic [ID_BITS-1:0]          id_t;
  typedef logic [PORT_HANDLE_BITS-1:0] port_handle_t;

  // request codes
  localparam opcode_t OP_ALLOC  = 2'd0;
  localparam opcode_t OP_LOOKUP = 2'd1;
  localparam opcode_t OP_FREE   = 2'd2;

  // result codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic rd;      // read the current valid-bit row and handle
    logic step;    // move the scan to the next row
    logic commit;  // update the table and load the result register
    logic clr_wr;  // clearing pass: initialise one row
  } nft_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // outcome of the current item is known
    logic clr_last;   // clearing pass is on its last row
    logic out_free;   // result register can take a new item
  } nft_sts_t;

  // width of one valid-bit row: 32, or the next power of two for tiny tables
  function automatic int word_bits(input int n);
    return (n >= 32) ? 32 : (1 << $clog2(n));
  endfunction

endpackage

FILE: src/nft_req_if.sv
// Request channel of the next-fit ID table: valid/ready plus request fields.
// Depends on nft_pkg.
interface nft_req_if;
  import nft_pkg::*;

  logic         valid;
  logic         ready;
  opcode_t      opcode;
  id_t          slot_id;
  port_handle_t object_handle;

  modport source (output valid, opcode, slot_id, object_handle, input ready);
  modport sink   (input valid, opcode, slot_id, object_handle, output ready);
endinterface

FILE: src/nft_rsp_if.sv
// Result channel of the next-fit ID table: valid/ready plus result fields.
// Depends on nft_pkg.
interface nft_rsp_if;
  import nft_pkg::*;

  logic         valid;
  logic         ready;
  status_t      status;
  id_t          result_id;
  port_handle_t result_handle;

  modport source (output valid, status, result_id, result_handle, input ready);
  modport sink   (input valid, status, result_id, result_handle, output ready);
endinterface

FILE: src/nft_ctrl.sv
// Controller of the next-fit ID table: clearing pass, request sequencing, scan loop.
// Depends on nft_pkg; drives nft_dp through nft_cmd_t.
module nft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nft_pkg::nft_sts_t sts,
  output nft_pkg::nft_cmd_t cmd
);
  import nft_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.scan_done) begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/nft_dp.sv
// Datapath of the next-fit ID table: valid-bit row memory, handle memory,
// free-slot search over one row, last-given register and result register.
// Depends on nft_pkg and next_fit_id_table_defines.svh; commanded by nft_ctrl.
`include "next_fit_id_table_defines.svh"

module nft_dp #(
  parameter int SLOT_COUNT  = nft_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = nft_pkg::HANDLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nft_pkg::nft_cmd_t     cmd,
  output nft_pkg::nft_sts_t     sts,
  input  nft_pkg::opcode_t      in_opcode,
  input  nft_pkg::id_t          in_slot_id,
  input  nft_pkg::port_handle_t in_object_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nft_pkg::status_t      out_status,
  output nft_pkg::id_t          out_result_id,
  output nft_pkg::port_handle_t out_result_handle
);
  import nft_pkg::*;

  localparam int W    = word_bits(SLOT_COUNT);
  localparam int WB   = $clog2(W);
  localparam int ROWS = (SLOT_COUNT + W - 1) / W;
  localparam int RB   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int GW   = RB + WB;
  localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int VW   = $clog2(ROWS + 1);

  // storage
  logic [W-1:0]           vmem [ROWS];
  logic [HANDLE_BITS-1:0] hmem [SLOT_COUNT];

  // request registers
  opcode_t                op_r;
  id_t                    id_r;
  logic                   id_ok_r;
  logic [HANDLE_BITS-1:0] hnd_r;

  // scan and table state
  id_t          last_r;
  logic [RB-1:0] row_r;
  logic [VW-1:0] visit_r;
  logic [WB-1:0] sb_r;
  logic [W-1:0]  vrd_r;
  logic [HANDLE_BITS-1:0] hrd_r;

  // result register
  logic         out_valid_r;
  status_t      out_status_r;
  id_t          out_id_r;
  port_handle_t out_handle_r;

  // combinational
  logic [31:0]   next_last;
  logic [GW-1:0] start_g;
  logic [GW-1:0] in_id_g;
  logic [GW-1:0] id_g;
  logic [WB-1:0] id_bit;
  logic [RB-1:0] row_inc;
  logic [W-1:0]  init_word;
  logic [W-1:0]  allow;
  logic [W-1:0]  free_bits;
  logic          any_free;
  logic [WB-1:0] hit_bit;
  logic [GW-1:0] cand_g;
  logic          first_visit;
  logic          last_visit;
  logic          id_hit;
  logic          alloc_hit;
  logic          vwr_en;
  logic [W-1:0]  vwr_data;
  status_t       res_status;
  id_t           res_id;
  port_handle_t  res_handle;

  // scan start: one after the last ID given, wrapping at the table end
  assign next_last = 32'(last_r) + 32'd1;
  assign start_g   = (next_last == 32'(SLOT_COUNT)) ? '0 : GW'(next_last);
  assign in_id_g   = GW'(in_slot_id);
  assign id_g      = GW'(id_r);
  assign id_bit    = id_g[WB-1:0];
  assign row_inc   = (row_r == RB'(ROWS - 1)) ? '0 : row_r + RB'(1);

  // initial row content: slots past the table end read as taken
  always_comb begin
    for (int b = 0; b < W; b++) begin
      init_word[b] = (32'({row_r, WB'(b)}) >= 32'(SLOT_COUNT));
    end
  end

  // first visit looks at or above the start bit, the closing visit below it
  assign first_visit = (visit_r == '0);
  assign last_visit  = (visit_r == VW'(ROWS));

  always_comb begin
    for (int b = 0; b < W; b++) begin
      allow[b] = (!first_visit || (WB'(b) >= sb_r)) && (!last_visit || (WB'(b) < sb_r));
    end
  end

  assign free_bits = ~vrd_r & allow;
  assign any_free  = |free_bits;

  // lowest free bit of the row
  always_comb begin
    hit_bit = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_bit = WB'(b);
      end
    end
  end

  assign cand_g = {row_r, hit_bit};
  assign id_hit = id_ok_r && vrd_r[id_bit];

  // outcome of the current item
  always_comb begin
    res_status = ST_NOT_FOUND;
    res_id     = '0;
    res_handle = '0;
    alloc_hit  = 1'b0;
    vwr_data   = vrd_r;
    case (op_r)
      OP_ALLOC: begin
        if (any_free) begin
          alloc_hit  = 1'b1;
          res_status = ST_OK;
          res_id     = ID_BITS'(cand_g);
          vwr_data   = vrd_r | (W'(1) << hit_bit);
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        res_id = id_r;
        if (id_hit) begin
          res_status = ST_OK;
          res_handle = PORT_HANDLE_BITS'(hrd_r);
        end
      end
      OP_FREE: begin
        res_id = id_r;
        if (id_hit) begin
          res_status = ST_OK;
          vwr_data   = vrd_r & ~(W'(1) << id_bit);
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  assign vwr_en = cmd.commit && (alloc_hit || ((op_r == OP_FREE) && id_hit));

  // status to the controller
  assign sts.scan_done = (op_r != OP_ALLOC) || any_free || last_visit;
  assign sts.clr_last  = (row_r == RB'(ROWS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // valid-bit row memory
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      vmem[row_r] <= init_word;
    end else if (vwr_en) begin
      vmem[row_r] <= vwr_data;
    end
    if (cmd.rd) begin
      vrd_r <= vmem[row_r];
    end
  end

  // handle memory
  always_ff @(posedge clk) begin
    if (cmd.commit && alloc_hit) begin
      hmem[SW'(cand_g)] <= hnd_r;
    end
    if (cmd.rd) begin
      hrd_r <= hmem[SW'(id_g)];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      id_r    <= in_slot_id;
      id_ok_r <= (32'(in_slot_id) < 32'(SLOT_COUNT));
      hnd_r   <= HANDLE_BITS'(in_object_handle);
      sb_r    <= start_g[WB-1:0];
    end
  end

  // row pointer, visit count and last-given ID
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      visit_r <= '0;
      last_r  <= '0;
    end else begin
      if (cmd.load) begin
        visit_r <= '0;
        row_r   <= (in_opcode == OP_ALLOC) ? start_g[GW-1:WB] : in_id_g[GW-1:WB];
      end else if (cmd.step) begin
        visit_r <= visit_r + VW'(1);
        row_r   <= row_inc;
      end else if (cmd.clr_wr) begin
        row_r   <= row_inc;
      end
      if (cmd.commit && alloc_hit) begin
        last_r <= ID_BITS'(cand_g);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_handle_r <= res_handle;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_result_handle = out_handle_r;

  // checks
  `NFT_ASSERT(a_commit_slot_free, cmd.commit |-> (!out_valid_r || out_ready))
  `NFT_ASSERT(a_commit_shows_result, cmd.commit |=> out_valid_r)
  `NFT_ASSERT(a_last_follows_alloc, (cmd.commit && alloc_hit) |=> (last_r == $past(ID_BITS'(cand_g))))
  `NFT_ASSERT(a_visit_bounded, visit_r <= VW'(ROWS))
  `NFT_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r)

endmodule

FILE: src/next_fit_id_table.sv
// Next-fit ID table, top level: request channel in, one result item per request out.
// Opcodes: allocate (next free ID after the last one given), lookup, free.
// Steps: the request is captured when accepted, then each valid-bit row it visits
// is read and checked in turn, one memory read per row. A lookup, free or unknown
// opcode visits only the row of its ID; an allocate walks on past full rows until
// it finds a free slot or has come back to the bits below its start. The result
// then loads into the result register. At most one request is in progress; a new
// request is taken once the previous result sits in the result register.
// Stalls: while out_chan.ready is low the result is held; a finished request
// waits in its last step until the result register frees, and in_chan.ready
// stays low meanwhile.
// Reset (synchronous, rst_n low): all IDs free, last given ID 0. After reset a
// clearing pass initialises the valid-bit rows, one per cycle; no request is
// accepted until it ends.
// A table-full allocate returns status 2 and leaves the table unchanged.
// Depends on nft_pkg, nft_req_if, nft_rsp_if, nft_ctrl and nft_dp.
module next_fit_id_table #(
  parameter int SLOT_COUNT  = nft_pkg::SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = nft_pkg::HANDLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nft_req_if.sink   in_chan,
  nft_rsp_if.source out_chan
);
  import nft_pkg::*;

  nft_cmd_t cmd;
  nft_sts_t sts;

  // sequencing
  nft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and result path
  nft_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_chan.opcode),
    .in_slot_id        (in_chan.slot_id),
    .in_object_handle  (in_chan.object_handle),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_status        (out_chan.status),
    .out_result_id     (out_chan.result_id),
    .out_result_handle (out_chan.result_handle)
  );

endmodule
